// ----- hw/rtl/pst_pkg.sv -----
// ----------------------------------------------------------------------------
// pst_pkg
// Shared widths, payload types, register codes and the arctangent table for
// the point-in-sector test.
// ----------------------------------------------------------------------------
package pst_pkg;

  localparam int COORD_BITS = 24;
  localparam int ANGLE_BITS = 16;

  localparam int DIFF_W  = COORD_BITS + 1;   // centre-relative coordinate
  localparam int DIST_W  = COORD_BITS + 1;   // horizontal distance
  localparam int CIN_W   = COORD_BITS + 2;   // CORDIC operand
  localparam int ROOT_W  = COORD_BITS + 2;   // square root digits
  localparam int SQ_W    = 2 * ROOT_W;       // radicand
  localparam int REM_W   = ROOT_W + 2;
  localparam int CFG_W   = (COORD_BITS + 1 > ANGLE_BITS + 1) ? COORD_BITS + 1
                                                             : ANGLE_BITS + 1;
  localparam int CFG_IDX_W = 3;

  localparam int NORM_W     = 41;            // normalize until bit 40 is set
  localparam int NORM_STEPS = 6;
  localparam int DP_W       = 46;
  localparam int Z_W        = 32;
  localparam int ITER       = 32;

  localparam int CORDIC_LAT = 1 + NORM_STEPS + ITER + 1;
  localparam int SQRT_LAT   = ROOT_W + 2;
  localparam int BACK_LAT   = SQRT_LAT + CORDIC_LAT;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTRE_X   = 3'd0,
    REG_CENTRE_Y   = 3'd1,
    REG_AZIMUTH    = 3'd2,
    REG_BASE_ANGLE = 3'd3,
    REG_ELEV_LOW   = 3'd4,
    REG_ELEV_HIGH  = 3'd5,
    REG_RANGE_NEAR = 3'd6,
    REG_RANGE_FAR  = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] point_h;
  } pst_in_t;

  typedef struct packed {
    logic                  inside_res;
    logic                  bearing_ok;
    logic                  elevation_ok;
    logic                  range_ok;
    logic [DIST_W-1:0]     distance;
    logic [ANGLE_BITS-1:0] bearing;
  } pst_out_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] centre_x;
    logic signed [COORD_BITS-1:0] centre_y;
    logic [ANGLE_BITS-1:0]        azimuth;
    logic [ANGLE_BITS:0]          base_angle;
    logic signed [ANGLE_BITS-1:0] elev_low;
    logic signed [ANGLE_BITS-1:0] elev_high;
    logic [DIST_W-1:0]            range_near;
    logic [DIST_W-1:0]            range_far;
  } cfg_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0]     dx;
    logic signed [DIFF_W-1:0]     dy;
    logic signed [COORD_BITS-1:0] h;
  } item_t;

  // round(atan(2^-i) * 2^32 / (2*pi))
  function automatic logic [Z_W-1:0] atan_tab(input logic [4:0] i);
    logic [Z_W-1:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

// ----- hw/rtl/pst_front.sv -----
// ----------------------------------------------------------------------------
// pst_front
// Input stage: takes a point and forms its offset from the sector centre.
// ----------------------------------------------------------------------------
module pst_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  pst_pkg::pst_in_t                    in_data_i,
  input  logic signed [pst_pkg::COORD_BITS-1:0] centre_x_i,
  input  logic signed [pst_pkg::COORD_BITS-1:0] centre_y_i,
  input  logic                                full_i,
  output logic                                push_o,
  output pst_pkg::item_t                      push_data_o
);
  import pst_pkg::*;

  logic   valid_q, valid_d;
  item_t  item_q;
  logic   accept;

  assign in_stall_o = valid_q && full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = valid_q && !full_i;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.dx <= DIFF_W'(in_data_i.point_x) - DIFF_W'(centre_x_i);
      item_q.dy <= DIFF_W'(in_data_i.point_y) - DIFF_W'(centre_y_i);
      item_q.h  <= in_data_i.point_h;
    end
  end

  assign push_data_o = item_q;

endmodule

// ----- hw/rtl/pst_fifo.sv -----
// ----------------------------------------------------------------------------
// pst_fifo
// Short queue between the input stage and the compute pipeline.
// ----------------------------------------------------------------------------
module pst_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  pst_pkg::item_t  data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output pst_pkg::item_t  data_o
);
  import pst_pkg::*;

  item_t              mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_q, rd_q;
  logic [FIFO_AW:0]   cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o  = cnt_q == (FIFO_AW+1)'(FIFO_DEPTH);
  assign valid_o = cnt_q != '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ----- hw/rtl/pst_cordic.sv -----
// ----------------------------------------------------------------------------
// pst_cordic
// Pipelined vectoring CORDIC: atan2(y, x) as a rounded binary angle.
// Prerotation, six normalize stages, 32 micro-rotations, rounding.
// ----------------------------------------------------------------------------
module pst_cordic (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [pst_pkg::CIN_W-1:0]  x_i,
  input  logic signed [pst_pkg::CIN_W-1:0]  y_i,
  output logic [pst_pkg::ANGLE_BITS-1:0]    angle_o
);
  import pst_pkg::*;

  logic signed [NORM_W:0] xe, ye, xp, yp;
  logic [Z_W-1:0]         zp;
  logic                   yneg;

  logic [NORM_W-1:0] ax_q   [NORM_STEPS+1];
  logic [NORM_W-1:0] ay_q   [NORM_STEPS+1];
  logic              yneg_q [NORM_STEPS+1];
  logic [Z_W-1:0]    zn_q   [NORM_STEPS+1];
  logic              zn0_q  [NORM_STEPS+1];

  logic signed [DP_W-1:0] xs [ITER+1];
  logic signed [DP_W-1:0] ys [ITER+1];
  logic [Z_W-1:0]         zs [ITER+1];
  logic                   zf [ITER+1];

  logic [ANGLE_BITS-1:0] angle_q;
  logic [Z_W-1:0]        zsum;

  always_comb begin
    xe = (NORM_W+1)'(x_i);
    ye = (NORM_W+1)'(y_i);
    xp = xe;
    yp = ye;
    zp = '0;
    if (xe < 0) begin
      xp = -xe;
      yp = -ye;
      zp = 32'h8000_0000;
    end
    yneg = yp < 0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax_q[0]   <= xp[NORM_W-1:0];
      ay_q[0]   <= yneg ? NORM_W'(-yp) : yp[NORM_W-1:0];
      yneg_q[0] <= yneg;
      zn_q[0]   <= zp;
      zn0_q[0]  <= (xe == 0) && (ye == 0);
    end
  end

  for (genvar k = 0; k < NORM_STEPS; k++) begin : g_norm
    localparam int SH = 32 >> k;
    logic [NORM_W-1:0] orv;
    logic              sh_en;
    assign orv   = ax_q[k] | ay_q[k];
    assign sh_en = orv[NORM_W-1 -: SH] == '0;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ax_q[k+1]   <= sh_en ? (ax_q[k] << SH) : ax_q[k];
        ay_q[k+1]   <= sh_en ? (ay_q[k] << SH) : ay_q[k];
        yneg_q[k+1] <= yneg_q[k];
        zn_q[k+1]   <= zn_q[k];
        zn0_q[k+1]  <= zn0_q[k];
      end
    end
  end

  assign xs[0] = DP_W'(ax_q[NORM_STEPS]);
  assign ys[0] = yneg_q[NORM_STEPS] ? -DP_W'(ay_q[NORM_STEPS]) : DP_W'(ay_q[NORM_STEPS]);
  assign zs[0] = zn_q[NORM_STEPS];
  assign zf[0] = zn0_q[NORM_STEPS];

  for (genvar i = 0; i < ITER; i++) begin : g_iter
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (ys[i] >= 0) begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + atan_tab(5'(i));
        end else begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - atan_tab(5'(i));
        end
        zf[i+1] <= zf[i];
      end
    end
  end

  assign zsum = zs[ITER] + (Z_W'(1) << (Z_W - 1 - ANGLE_BITS));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      angle_q <= zf[ITER] ? '0 : zsum[Z_W-1 -: ANGLE_BITS];
    end
  end

  assign angle_o = angle_q;

endmodule

// ----- hw/rtl/pst_isqrt.sv -----
// ----------------------------------------------------------------------------
// pst_isqrt
// Pipelined restoring integer square root, one result digit per stage.
// ----------------------------------------------------------------------------
module pst_isqrt (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [pst_pkg::SQ_W-1:0]     val_i,
  output logic [pst_pkg::ROOT_W-1:0]   root_o
);
  import pst_pkg::*;

  logic [SQ_W-1:0]   val_q  [ROOT_W+1];
  logic [REM_W-1:0]  rem_q  [ROOT_W+1];
  logic [ROOT_W-1:0] root_q [ROOT_W+1];

  assign val_q[0]  = val_i;
  assign rem_q[0]  = '0;
  assign root_q[0] = '0;

  for (genvar i = 0; i < ROOT_W; i++) begin : g_step
    logic [REM_W+1:0] rem_sh, trial;
    assign rem_sh = {rem_q[i], val_q[i][2*(ROOT_W-1-i) +: 2]};
    assign trial  = {2'b00, root_q[i], 2'b01};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        val_q[i+1] <= val_q[i];
        if (rem_sh >= trial) begin
          rem_q[i+1]  <= REM_W'(rem_sh - trial);
          root_q[i+1] <= {root_q[i][ROOT_W-2:0], 1'b1};
        end else begin
          rem_q[i+1]  <= REM_W'(rem_sh);
          root_q[i+1] <= {root_q[i][ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign root_o = root_q[ROOT_W];

endmodule

// ----- hw/rtl/pst_back.sv -----
// ----------------------------------------------------------------------------
// pst_back
// Compute pipeline: bearing CORDIC, distance root, elevation CORDIC, the
// three window tests and the output register.
// ----------------------------------------------------------------------------
module pst_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pst_pkg::cfg_t     cfg_i,
  input  logic              valid_i,
  input  pst_pkg::item_t    data_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output pst_pkg::pst_out_t out_data_o
);
  import pst_pkg::*;

  logic                     en;
  logic [BACK_LAT-1:0]      vld_q;
  logic                     out_valid_q;
  pst_out_t                 out_q, res;

  logic [DIFF_W-1:0]        adx, ady;
  logic [2*DIFF_W-1:0]      sq1_q, sq2_q;
  logic [SQ_W-1:0]          sum_q;
  logic [ROOT_W-1:0]        root;
  logic [ANGLE_BITS-1:0]    bear_raw, elev_raw;

  logic signed [COORD_BITS-1:0] hd_q [SQRT_LAT];
  logic [ANGLE_BITS-1:0]        bd_q [SQRT_LAT];
  logic [DIST_W-1:0]            dd_q [CORDIC_LAT];

  logic [ANGLE_BITS-1:0]        bear, dlt, mag;
  logic [DIST_W-1:0]            hdist;
  logic signed [ANGLE_BITS-1:0] elev;

  assign en    = !out_valid_q || !out_stall_i;
  assign pop_o = en && valid_i;

  assign adx = data_i.dx < 0 ? DIFF_W'(-data_i.dx) : DIFF_W'(data_i.dx);
  assign ady = data_i.dy < 0 ? DIFF_W'(-data_i.dy) : DIFF_W'(data_i.dy);

  pst_cordic u_bear (
    .clk_i   (clk_i),
    .en_i    (en),
    .x_i     (CIN_W'(data_i.dx)),
    .y_i     (CIN_W'(data_i.dy)),
    .angle_o (bear_raw)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq1_q <= adx * adx;
      sq2_q <= ady * ady;
      sum_q <= SQ_W'(sq1_q) + SQ_W'(sq2_q);
      hd_q[0] <= data_i.h;
      for (int i = 1; i < SQRT_LAT; i++) begin
        hd_q[i] <= hd_q[i-1];
      end
      bd_q[0] <= bear_raw;
      for (int i = 1; i < SQRT_LAT; i++) begin
        bd_q[i] <= bd_q[i-1];
      end
      dd_q[0] <= root[DIST_W-1:0];
      for (int i = 1; i < CORDIC_LAT; i++) begin
        dd_q[i] <= dd_q[i-1];
      end
    end
  end

  pst_isqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .val_i  (sum_q),
    .root_o (root)
  );

  pst_cordic u_elev (
    .clk_i   (clk_i),
    .en_i    (en),
    .x_i     (CIN_W'(root[DIST_W-1:0])),
    .y_i     (CIN_W'(hd_q[SQRT_LAT-1])),
    .angle_o (elev_raw)
  );

  always_comb begin
    bear  = bd_q[SQRT_LAT-1];
    hdist = dd_q[CORDIC_LAT-1];
    elev  = elev_raw;
    dlt   = bear - cfg_i.azimuth;
    mag   = dlt[ANGLE_BITS-1] ? -dlt : dlt;
    res.bearing_ok   = cfg_i.base_angle[ANGLE_BITS] || ({mag, 1'b0} <= cfg_i.base_angle);
    res.range_ok     = (hdist >= cfg_i.range_near) && (hdist <= cfg_i.range_far);
    res.elevation_ok = (elev > cfg_i.elev_low) && (elev < cfg_i.elev_high);
    res.inside_res   = res.bearing_ok && res.range_ok && res.elevation_ok;
    res.distance     = hdist;
    res.bearing      = bear;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[BACK_LAT-2:0], valid_i};
      out_valid_q <= vld_q[BACK_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> $stable(vld_q))
    else $error("pipeline moved while output held");

  a_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(vld_q[BACK_LAT-1]))
    else $error("result appeared without a pipeline item");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_stall_i && !vld_q[BACK_LAT-1]) |=> !out_valid_q)
    else $error("taken result not retired");

endmodule

// ----- hw/rtl/point_in_sector_test_core.sv -----
// ----------------------------------------------------------------------------
// point_in_sector_test_core
// Tests 3-D points against a configured bearing, range and elevation sector.
// ----------------------------------------------------------------------------
// One point is accepted per cycle and one result leaves per cycle while the
// output is not stalled. A point passes one input stage, one queue slot, then
// the distance root (28 stages including the squaring) in series with the
// elevation CORDIC (40 stages), and the test/output register. The bearing
// CORDIC runs beside the root. A four-entry queue lets the input side keep
// taking points while the output is held, until the queue and the input
// stage are full.
module point_in_sector_test_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  pst_pkg::pst_in_t                  in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output pst_pkg::pst_out_t                 out_data_o,
  input  logic                              cfg_we_i,
  input  logic [pst_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [pst_pkg::CFG_W-1:0]         cfg_data_i
);
  import pst_pkg::*;

  cfg_t  cfg_q;
  logic  push, full, fifo_valid, pop;
  item_t push_data, fifo_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CENTRE_X:   cfg_q.centre_x   <= cfg_data_i[COORD_BITS-1:0];
        REG_CENTRE_Y:   cfg_q.centre_y   <= cfg_data_i[COORD_BITS-1:0];
        REG_AZIMUTH:    cfg_q.azimuth    <= cfg_data_i[ANGLE_BITS-1:0];
        REG_BASE_ANGLE: cfg_q.base_angle <= cfg_data_i[ANGLE_BITS:0];
        REG_ELEV_LOW:   cfg_q.elev_low   <= cfg_data_i[ANGLE_BITS-1:0];
        REG_ELEV_HIGH:  cfg_q.elev_high  <= cfg_data_i[ANGLE_BITS-1:0];
        REG_RANGE_NEAR: cfg_q.range_near <= cfg_data_i[DIST_W-1:0];
        REG_RANGE_FAR:  cfg_q.range_far  <= cfg_data_i[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  pst_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .centre_x_i  (cfg_q.centre_x),
    .centre_y_i  (cfg_q.centre_y),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  pst_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (fifo_valid),
    .data_o  (fifo_data)
  );

  pst_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .valid_i     (fifo_valid),
    .data_i      (fifo_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- tb/point_in_sector_test_core_tb.sv -----
// ----------------------------------------------------------------------------
// point_in_sector_test_core_tb
// Drives 3-D points through the sector test with random handshake gaps and
// checks every result against a bit-exact behavioral model or a typed row.
// ----------------------------------------------------------------------------
module point_in_sector_test_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pst_pkg::*;

  localparam logic signed [COORD_BITS-1:0] C_MAX = 24'sh7FFFFF;
  localparam logic signed [COORD_BITS-1:0] C_MIN = -24'sh800000;

  typedef struct packed {
    pst_in_t  pt;
    logic     typed;
    pst_out_t res;
  } dir_row_t;

  localparam logic [31:0] ATAN_STEP [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000};

  // at the centre with reset settings: bearing and range pass, elevation not
  localparam dir_row_t DIR_ROWS [16] = '{
    '{'{24'sd0, 24'sd0, 24'sd0}, 1'b1, '{1'b0, 1'b1, 1'b0, 1'b1, 25'd0, 16'd0}},
    '{'{C_MAX, C_MAX, C_MAX}, 1'b0, '0},
    '{'{C_MIN, C_MIN, C_MIN}, 1'b0, '0},
    '{'{C_MIN, C_MAX, 24'sd0}, 1'b0, '0},
    '{'{C_MAX, C_MIN, C_MIN}, 1'b0, '0},
    '{'{24'sd0, 24'sd0, C_MAX}, 1'b0, '0},
    '{'{24'sd0, 24'sd0, C_MIN}, 1'b0, '0},
    '{'{24'sd1, 24'sd0, 24'sd0}, 1'b0, '0},
    '{'{24'sd0, 24'sd1, 24'sd0}, 1'b0, '0},
    '{'{-24'sd1, 24'sd0, 24'sd0}, 1'b0, '0},
    '{'{24'sd0, -24'sd1, 24'sd1}, 1'b0, '0},
    '{'{-24'sd1, -24'sd1, -24'sd1}, 1'b0, '0},
    '{'{C_MIN, 24'sd0, C_MAX}, 1'b0, '0},
    '{'{24'sd0, C_MIN, 24'sd1}, 1'b0, '0},
    '{'{24'sd1000, 24'sd1000, 24'sd1000}, 1'b0, '0},
    '{'{-24'sd5, 24'sd3, -24'sd7}, 1'b0, '0}};

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid;
  logic              in_stall;
  pst_in_t           in_data;
  logic              out_valid;
  logic              out_stall;
  pst_out_t          out_data;
  logic              cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]  cfg_data;

  cfg_t      sector;
  pst_out_t  pending_results [$];
  int        fail_count;
  int        in_idle_pct;
  int        out_stall_pct;
  int        hold_cycles;

  point_in_sector_test_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned root, rem, trial;
    root = 0;
    rem  = 0;
    for (int k = 32; k >= 0; k--) begin
      rem   = (rem << 2) | ((v >> (2 * k)) & 64'd3);
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  // atan2(y, x) in 2^-32 turn
  function automatic logic [31:0] turn_of(longint x, longint y);
    logic [31:0] z;
    longint unsigned ax, ay, m;
    longint xn, yn;
    bit yneg;
    int sh;
    z = '0;
    if (x == 0 && y == 0) return '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h80000000;
    end
    yneg = y < 0;
    ax = x;
    ay = yneg ? -y : y;
    m  = ax > ay ? ax : ay;
    sh = 0;
    while (m < (64'd1 << 40)) begin
      m  = m << 1;
      sh++;
    end
    x = longint'(ax << sh);
    y = yneg ? -longint'(ay << sh) : longint'(ay << sh);
    for (int i = 0; i < 32; i++) begin
      if (y >= 0) begin
        xn = x + (y >>> i);
        yn = y - (x >>> i);
        z  = z + ATAN_STEP[i];
      end else begin
        xn = x - (y >>> i);
        yn = y + (x >>> i);
        z  = z - ATAN_STEP[i];
      end
      x = xn;
      y = yn;
    end
    return z;
  endfunction

  function automatic logic [ANGLE_BITS-1:0] binary_angle(logic [31:0] z);
    logic [32:0] r;
    r = {1'b0, z} + 33'h8000;
    return r[31:16];
  endfunction

  function automatic pst_out_t sector_result(pst_in_t p);
    longint dx, dy;
    longint unsigned ax, ay, hdist, mag;
    logic [ANGLE_BITS-1:0] brg, diff;
    logic signed [ANGLE_BITS-1:0] elev;
    pst_out_t r;
    dx    = longint'(p.point_x) - longint'(sector.centre_x);
    dy    = longint'(p.point_y) - longint'(sector.centre_y);
    ax    = dx < 0 ? -dx : dx;
    ay    = dy < 0 ? -dy : dy;
    hdist = floor_sqrt(ax * ax + ay * ay);
    brg   = binary_angle(turn_of(dx, dy));
    elev  = binary_angle(turn_of(longint'(hdist), longint'(p.point_h)));
    diff  = brg - sector.azimuth;
    mag   = diff >= 16'h8000 ? 64'd65536 - 64'(diff) : 64'(diff);
    r.bearing_ok   = sector.base_angle >= 17'd65536 || 2 * mag <= sector.base_angle;
    r.range_ok     = hdist >= sector.range_near && hdist <= sector.range_far;
    r.elevation_ok = elev > sector.elev_low && elev < sector.elev_high;
    r.inside_res   = r.bearing_ok && r.range_ok && r.elevation_ok;
    r.distance     = hdist[DIST_W-1:0];
    r.bearing      = brg;
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall   <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < out_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    pst_out_t e;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with no expectation: %p", out_data);
        fail_count++;
      end else begin
        e = pending_results.pop_front();
        if (out_data.inside_res !== e.inside_res) begin
          $error("inside_res exp %0d got %0d", e.inside_res, out_data.inside_res);
          fail_count++;
        end
        if (out_data.bearing_ok !== e.bearing_ok) begin
          $error("bearing_ok exp %0d got %0d", e.bearing_ok, out_data.bearing_ok);
          fail_count++;
        end
        if (out_data.elevation_ok !== e.elevation_ok) begin
          $error("elevation_ok exp %0d got %0d", e.elevation_ok, out_data.elevation_ok);
          fail_count++;
        end
        if (out_data.range_ok !== e.range_ok) begin
          $error("range_ok exp %0d got %0d", e.range_ok, out_data.range_ok);
          fail_count++;
        end
        if (out_data.distance !== e.distance) begin
          $error("distance exp %0d got %0d", e.distance, out_data.distance);
          fail_count++;
        end
        if (out_data.bearing !== e.bearing) begin
          $error("bearing exp %0d got %0d", e.bearing, out_data.bearing);
          fail_count++;
        end
      end
    end
  end

  task automatic write_reg(cfg_reg_e r, logic [CFG_W-1:0] v);
    cfg_we   <= 1'b1;
    cfg_idx  <= r;
    cfg_data <= v;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    case (r)
      REG_CENTRE_X:   sector.centre_x   = v[COORD_BITS-1:0];
      REG_CENTRE_Y:   sector.centre_y   = v[COORD_BITS-1:0];
      REG_AZIMUTH:    sector.azimuth    = v[ANGLE_BITS-1:0];
      REG_BASE_ANGLE: sector.base_angle = v[ANGLE_BITS:0];
      REG_ELEV_LOW:   sector.elev_low   = v[ANGLE_BITS-1:0];
      REG_ELEV_HIGH:  sector.elev_high  = v[ANGLE_BITS-1:0];
      REG_RANGE_NEAR: sector.range_near = v[DIST_W-1:0];
      REG_RANGE_FAR:  sector.range_far  = v[DIST_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_sector(cfg_t c);
    write_reg(REG_CENTRE_X, CFG_W'(c.centre_x));
    write_reg(REG_CENTRE_Y, CFG_W'(c.centre_y));
    write_reg(REG_AZIMUTH, CFG_W'(c.azimuth));
    write_reg(REG_BASE_ANGLE, CFG_W'(c.base_angle));
    write_reg(REG_ELEV_LOW, CFG_W'(c.elev_low));
    write_reg(REG_ELEV_HIGH, CFG_W'(c.elev_high));
    write_reg(REG_RANGE_NEAR, CFG_W'(c.range_near));
    write_reg(REG_RANGE_FAR, CFG_W'(c.range_far));
  endtask

  task automatic send_point(pst_in_t p, logic typed, pst_out_t res);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    pending_results.push_back(typed ? res : sector_result(p));
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic logic signed [COORD_BITS-1:0] near_coord(longint base);
    longint v;
    v = base + (longint'($signed($urandom)) >>> $urandom_range(8, 31));
    if (v > longint'(C_MAX)) v = longint'(C_MAX);
    if (v < longint'(C_MIN)) v = longint'(C_MIN);
    return v[COORD_BITS-1:0];
  endfunction

  function automatic pst_in_t random_point;
    pst_in_t p;
    if ($urandom_range(3) == 0) begin
      p.point_x = 24'($urandom);
      p.point_y = 24'($urandom);
      p.point_h = 24'($urandom);
    end else begin
      p.point_x = near_coord(longint'(sector.centre_x));
      p.point_y = near_coord(longint'(sector.centre_y));
      p.point_h = near_coord(0);
    end
    return p;
  endfunction

  function automatic cfg_t random_sector;
    cfg_t c;
    longint unsigned reach;
    c.centre_x   = ($urandom_range(3) == 0) ? 24'($urandom) : near_coord(0);
    c.centre_y   = ($urandom_range(3) == 0) ? 24'($urandom) : near_coord(0);
    c.azimuth    = 16'($urandom);
    c.base_angle = ($urandom_range(7) == 0) ? 17'd65536 : 17'($urandom_range(65536));
    c.elev_low   = 16'($urandom_range(32768) - 16384);
    c.elev_high  = 16'($urandom_range(32768) - 16384);
    if ($urandom_range(5) != 0 && c.elev_low > c.elev_high) begin
      c.elev_low  = c.elev_high;
      c.elev_high = 16'($urandom_range(32768) - 16384);
    end
    reach        = 64'd1 << $urandom_range(4, 25);
    c.range_near = 25'($urandom_range(0, 32'(reach >> 1)));
    c.range_far  = ($urandom_range(7) == 0) ? 25'($urandom)
                                            : c.range_near + 25'(reach >> 1);
    return c;
  endfunction

  initial begin
    cfg_t c;
    int idle_in  [5];
    int idle_out [5];
    idle_in       = '{0, 46, 0, 15, 0};
    idle_out      = '{0, 0, 46, 15, 0};
    fail_count    = 0;
    in_idle_pct   = 0;
    out_stall_pct = 0;
    hold_cycles   = 0;
    sector        = '0;
    rst_ni        = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_stall     = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = REG_CENTRE_X;
    cfg_data      = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        c = '{24'sd0, 24'sd0, 16'd0, 17'd65536, -16'sd16384, 16'sd16384,
              25'd0, 25'h1FFFFFF};
        write_sector(c);
      end else if (ph == 2) begin
        // inverted elevation and range, zero-width bearing window
        c = '{C_MIN, C_MAX, 16'hFFFF, 17'd0, 16'sd16384, -16'sd16384,
              25'h1FFFFFF, 25'd0};
        write_sector(c);
      end
      foreach (DIR_ROWS[i])
        send_point(DIR_ROWS[i].pt, DIR_ROWS[i].typed && ph == 0, DIR_ROWS[i].res);
      drain();
    end

    for (int ph = 0; ph < 5; ph++) begin
      in_idle_pct   = idle_in[ph];
      out_stall_pct = idle_out[ph];
      for (int blk = 0; blk < 4; blk++) begin
        write_sector(random_sector());
        if (ph == 4 && blk == 0) begin
          // long hold with more points than the pipeline holds
          hold_cycles = 300;
          repeat (120) send_point(random_point(), 1'b0, '0);
        end else begin
          repeat (20) send_point(random_point(), 1'b0, '0);
        end
        drain();
      end
    end

    in_idle_pct   = 0;
    out_stall_pct = 0;
    drain();
    repeat (80) @(posedge clk_i);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
